### sv/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types, register indexes and window helpers for the 2-D max pool.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

  localparam int unsigned SIZE_W    = 9;   // plane sizes and pixel positions
  localparam int unsigned UE_W      = 10;  // unclipped window end, one past last
  localparam int unsigned IDX_W     = 9;   // pooled row / column index
  localparam int unsigned WIN_W     = 4;
  localparam int unsigned PAD_W     = 3;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAX_STRIDE = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_H    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_R = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_R    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_C    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_H  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_W  = 3'd7;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [WIN_W-1:0]  win_h;
    logic [WIN_W-1:0]  win_w;
    logic [WIN_W-1:0]  stride_r;
    logic [WIN_W-1:0]  stride_c;
    logic [PAD_W-1:0]  pad_r;
    logic [PAD_W-1:0]  pad_c;
    logic [SIZE_W-1:0] plane_h;
    logic [SIZE_W-1:0] plane_w;
  } cfg_t;

  // One accepted pixel as seen by the back end
  typedef struct packed {
    logic [SIZE_W-1:0] row;
    logic [SIZE_W-1:0] col;
    logic [IDX_W-1:0]  k_row;
    logic [UE_W-1:0]   end_row;
    logic [IDX_W-1:0]  k_col;
    logic [UE_W-1:0]   end_col;
  } task_t;

  // Window with unclipped end ue (exclusive) exists and clips to end at pos.
  function automatic logic closes(input logic [UE_W-1:0]   ue,
                                  input logic [SIZE_W-1:0] pos,
                                  input logic [SIZE_W-1:0] size,
                                  input logic [PAD_W-1:0]  pad);
    logic [UE_W-1:0] lim;
    logic [UE_W-1:0] e;
    lim = UE_W'(size) + UE_W'(pad);
    e   = (ue > UE_W'(size)) ? UE_W'(size) : ue;
    return (ue <= lim) && (e == UE_W'(pos) + UE_W'(1));
  endfunction

  // Unclipped end of the first window
  function automatic logic [UE_W-1:0] first_end(input logic [WIN_W-1:0] win,
                                                input logic [PAD_W-1:0] pad);
    return UE_W'(win) - UE_W'(pad);
  endfunction

endpackage

`default_nettype wire

### sv/mp2d_if.sv
// ----------------------------------------------------------------------------
// mp2d_if
// Valid/ready channels for pixels in and pooled results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp2d_pix_if #(
  parameter int unsigned DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mp2d_res_if #(
  parameter int unsigned DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] max_value;
  logic [8:0]                   out_row;
  logic [8:0]                   out_col;
  logic                         last;

  modport source (output valid, output max_value, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input max_value, input out_row, input out_col,
                  input last, output ready);
endinterface

`default_nettype wire

### sv/mp2d_ram.sv
// ----------------------------------------------------------------------------
// mp2d_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/mp2d_queue.sv
// ----------------------------------------------------------------------------
// mp2d_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

### sv/mp2d_front.sv
// ----------------------------------------------------------------------------
// mp2d_front
// Takes pixels, tracks row/column position and the next closing window on
// each axis, writes the line store and queues one task per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_front #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned PITCH      = 256,
  parameter int unsigned NSLOT      = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mp2d_pkg::cfg_t         cfg_i,
  input  wire logic                   cfg_wr_i,
  mp2d_pix_if.sink                    pix_in,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output mp2d_pkg::task_t             task_o,
  output logic [$clog2(NSLOT)-1:0]    slot_o,
  output logic                        ram_we_o,
  output logic [$clog2(NSLOT*PITCH)-1:0] ram_waddr_o,
  output logic [DATA_WIDTH-1:0]       ram_wdata_o
);

  localparam int unsigned SLW = $clog2(NSLOT);
  localparam int unsigned XW  = $clog2(PITCH);

  localparam logic [1:0] F_RUN  = 2'd0;
  localparam logic [1:0] F_WRAP = 2'd1;
  localparam logic [1:0] F_SEEK = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic                        resync_q, resync_d;
  logic [mp2d_pkg::SIZE_W-1:0] row_q, row_d, col_q, col_d, row_inc;
  logic [SLW-1:0]              slot_q, slot_d;
  logic [mp2d_pkg::IDX_W-1:0]  kr_q, kr_d, kc_q, kc_d;
  logic [mp2d_pkg::UE_W-1:0]   er_q, er_d, ec_q, ec_d, er0, ec0;
  logic                        accept, col_last, row_last, col_wrap, row_wrap;
  logic                        seek_r, seek_c;

  assign er0      = mp2d_pkg::first_end(cfg_i.win_h, cfg_i.pad_r);
  assign ec0      = mp2d_pkg::first_end(cfg_i.win_w, cfg_i.pad_c);
  assign col_last = (col_q == cfg_i.plane_w - mp2d_pkg::SIZE_W'(1));
  assign row_last = (row_q == cfg_i.plane_h - mp2d_pkg::SIZE_W'(1));
  // position correction after a size change
  assign col_wrap = (col_q >= cfg_i.plane_w);
  assign row_inc  = col_wrap ? row_q + mp2d_pkg::SIZE_W'(1) : row_q;
  assign row_wrap = (row_inc >= cfg_i.plane_h);
  assign seek_r   = (er_q <= mp2d_pkg::UE_W'(row_q));
  assign seek_c   = (ec_q <= mp2d_pkg::UE_W'(col_q));

  assign pix_in.ready = (state_q == F_RUN) && !resync_q && !q_full_i;
  assign accept       = pix_in.valid && pix_in.ready;

  assign push_o         = accept;
  assign task_o.row     = row_q;
  assign task_o.col     = col_q;
  assign task_o.k_row   = kr_q;
  assign task_o.end_row = er_q;
  assign task_o.k_col   = kc_q;
  assign task_o.end_col = ec_q;
  assign slot_o         = slot_q;
  assign ram_we_o       = accept;
  assign ram_waddr_o    = {slot_q, XW'(col_q)};
  assign ram_wdata_o    = pix_in.pixel;

  always_comb begin
    state_d  = state_q;
    resync_d = resync_q;
    row_d    = row_q;
    col_d    = col_q;
    slot_d   = slot_q;
    kr_d     = kr_q;
    er_d     = er_q;
    kc_d     = kc_q;
    ec_d     = ec_q;
    case (state_q)
      F_RUN: begin
        if (accept) begin
          if (col_last) begin
            col_d  = '0;
            slot_d = slot_q + SLW'(1);
            kc_d   = '0;
            ec_d   = ec0;
            if (row_last) begin
              row_d = '0;
              kr_d  = '0;
              er_d  = er0;
            end else begin
              row_d = row_q + mp2d_pkg::SIZE_W'(1);
              if (mp2d_pkg::closes(er_q, row_q, cfg_i.plane_h, cfg_i.pad_r)) begin
                kr_d = kr_q + mp2d_pkg::IDX_W'(1);
                er_d = er_q + mp2d_pkg::UE_W'(cfg_i.stride_r);
              end
            end
          end else begin
            col_d = col_q + mp2d_pkg::SIZE_W'(1);
            if (mp2d_pkg::closes(ec_q, col_q, cfg_i.plane_w, cfg_i.pad_c)) begin
              kc_d = kc_q + mp2d_pkg::IDX_W'(1);
              ec_d = ec_q + mp2d_pkg::UE_W'(cfg_i.stride_c);
            end
          end
        end else if (resync_q && pix_in.valid) begin
          state_d = F_WRAP;
        end
      end
      F_WRAP: begin
        resync_d = 1'b0;
        if (col_wrap) begin
          col_d = '0;
        end
        row_d = row_wrap ? '0 : row_inc;
        if (col_wrap || row_wrap) begin
          slot_d = slot_q + SLW'(1);
        end
        kr_d    = '0;
        er_d    = er0;
        kc_d    = '0;
        ec_d    = ec0;
        state_d = F_SEEK;
      end
      F_SEEK: begin
        // walk both axes up to the first window still open at this position
        if (seek_r) begin
          kr_d = kr_q + mp2d_pkg::IDX_W'(1);
          er_d = er_q + mp2d_pkg::UE_W'(cfg_i.stride_r);
        end
        if (seek_c) begin
          kc_d = kc_q + mp2d_pkg::IDX_W'(1);
          ec_d = ec_q + mp2d_pkg::UE_W'(cfg_i.stride_c);
        end
        if (!seek_r && !seek_c) begin
          state_d = F_RUN;
        end
      end
      default: state_d = F_RUN;
    endcase
    if (cfg_wr_i) begin
      resync_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_RUN;
      resync_q <= 1'b1;
      row_q    <= '0;
      col_q    <= '0;
      slot_q   <= '0;
      kr_q     <= '0;
      er_q     <= '0;
      kc_q     <= '0;
      ec_q     <= '0;
    end else begin
      state_q  <= state_d;
      resync_q <= resync_d;
      row_q    <= row_d;
      col_q    <= col_d;
      slot_q   <= slot_d;
      kr_q     <= kr_d;
      er_q     <= er_d;
      kc_q     <= kc_d;
      ec_q     <= ec_d;
    end
  end

endmodule

`default_nettype wire

### sv/mp2d_back.sv
// ----------------------------------------------------------------------------
// mp2d_back
// Walks the windows closed by one pixel in pooled raster order, scans each
// clipped window out of the line store and emits its maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_back #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned PITCH      = 256,
  parameter int unsigned NSLOT      = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mp2d_pkg::cfg_t            cfg_i,
  input  wire logic                      q_empty_i,
  input  wire mp2d_pkg::task_t           q_task_i,
  input  wire logic [$clog2(NSLOT)-1:0]  q_slot_i,
  output logic                           q_pop_o,
  output logic [$clog2(NSLOT*PITCH)-1:0] ram_raddr_o,
  input  wire logic [DATA_WIDTH-1:0]     ram_rdata_i,
  mp2d_res_if.source                     res_out
);

  localparam int unsigned SLW = $clog2(NSLOT);
  localparam int unsigned XW  = $clog2(PITCH);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_START = 3'd1;
  localparam logic [2:0] B_SCAN  = 3'd2;
  localparam logic [2:0] B_FIN   = 3'd3;
  localparam logic [2:0] B_EMIT  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [mp2d_pkg::IDX_W-1:0]   ka_q, ka_d, kb_q, kb_d;
  logic [mp2d_pkg::UE_W-1:0]    ea_q, ea_d, eb_q, eb_d, rs, cs, ea_nx, eb_nx;
  logic [mp2d_pkg::WIN_W-1:0]   d_q, d_d, dmax_q, dmax_d;
  logic [mp2d_pkg::SIZE_W-1:0]  x_q, x_d, cs_q, cs_d;
  logic signed [DATA_WIDTH-1:0] best_q, best_d, rdata_s, acc;
  logic                         rdv_q, rdv_d;
  logic                         out_v_q, out_v_d, out_free, load;
  logic signed [DATA_WIDTH-1:0] max_q;
  logic [mp2d_pkg::IDX_W-1:0]   orow_q, ocol_q;
  logic                         last_q, more_c, more_r;

  assign rdata_s  = ram_rdata_i;
  assign acc      = (rdv_q && (rdata_s > best_q)) ? rdata_s : best_q;
  assign rs       = (ea_q >= mp2d_pkg::UE_W'(cfg_i.win_h)) ?
                    ea_q - mp2d_pkg::UE_W'(cfg_i.win_h) : '0;
  assign cs       = (eb_q >= mp2d_pkg::UE_W'(cfg_i.win_w)) ?
                    eb_q - mp2d_pkg::UE_W'(cfg_i.win_w) : '0;
  assign ea_nx    = ea_q + mp2d_pkg::UE_W'(cfg_i.stride_r);
  assign eb_nx    = eb_q + mp2d_pkg::UE_W'(cfg_i.stride_c);
  assign more_c   = mp2d_pkg::closes(eb_nx, q_task_i.col, cfg_i.plane_w, cfg_i.pad_c);
  assign more_r   = mp2d_pkg::closes(ea_nx, q_task_i.row, cfg_i.plane_h, cfg_i.pad_r);
  assign out_free = !out_v_q || res_out.ready;

  // row d back from the newest row lives d slots below it
  assign ram_raddr_o = {q_slot_i - SLW'(d_q), XW'(x_q)};

  always_comb begin
    state_d = state_q;
    ka_d    = ka_q;
    kb_d    = kb_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    d_d     = d_q;
    dmax_d  = dmax_q;
    x_d     = x_q;
    cs_d    = cs_q;
    best_d  = acc;
    rdv_d   = 1'b0;
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          if (mp2d_pkg::closes(q_task_i.end_row, q_task_i.row, cfg_i.plane_h,
                               cfg_i.pad_r) &&
              mp2d_pkg::closes(q_task_i.end_col, q_task_i.col, cfg_i.plane_w,
                               cfg_i.pad_c)) begin
            ka_d    = q_task_i.k_row;
            ea_d    = q_task_i.end_row;
            kb_d    = q_task_i.k_col;
            eb_d    = q_task_i.end_col;
            state_d = B_START;
          end else begin
            q_pop_o = 1'b1;
          end
        end
      end
      B_START: begin
        dmax_d  = mp2d_pkg::WIN_W'(mp2d_pkg::UE_W'(q_task_i.row) - rs);
        cs_d    = mp2d_pkg::SIZE_W'(cs);
        x_d     = mp2d_pkg::SIZE_W'(cs);
        d_d     = '0;
        best_d  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        state_d = B_SCAN;
      end
      B_SCAN: begin
        rdv_d = 1'b1;
        if (x_q == q_task_i.col) begin
          x_d = cs_q;
          if (d_q == dmax_q) begin
            state_d = B_FIN;
          end else begin
            d_d = d_q + mp2d_pkg::WIN_W'(1);
          end
        end else begin
          x_d = x_q + mp2d_pkg::SIZE_W'(1);
        end
      end
      B_FIN: begin
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (more_c) begin
            kb_d    = kb_q + mp2d_pkg::IDX_W'(1);
            eb_d    = eb_nx;
            state_d = B_START;
          end else if (more_r) begin
            ka_d    = ka_q + mp2d_pkg::IDX_W'(1);
            ea_d    = ea_nx;
            kb_d    = q_task_i.k_col;
            eb_d    = q_task_i.end_col;
            state_d = B_START;
          end else begin
            q_pop_o = 1'b1;
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    out_v_d = load ? 1'b1 : (res_out.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rdv_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ka_q   <= ka_d;
    kb_q   <= kb_d;
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    d_q    <= d_d;
    dmax_q <= dmax_d;
    x_q    <= x_d;
    cs_q   <= cs_d;
    best_q <= best_d;
    if (load) begin
      max_q  <= best_q;
      orow_q <= ka_q;
      ocol_q <= kb_q;
      last_q <= !more_c && !more_r;
    end
  end

  assign res_out.valid     = out_v_q;
  assign res_out.max_value = max_q;
  assign res_out.out_row   = orow_q;
  assign res_out.out_col   = ocol_q;
  assign res_out.last      = last_q;

`ifndef SYNTHESIS
  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> ($past(state_q) == B_SCAN))
    else $error("read data flagged without a scan cycle");
  a_row_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN) |-> (d_q <= dmax_q))
    else $error("scan row beyond window");
  a_pop_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == B_IDLE || state_q == B_EMIT))
    else $error("task released mid-window");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result overwritten before transaction");
`endif

endmodule

`default_nettype wire

### sv/max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over signed feature planes in raster order.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                   Transaction
// pix_in    in   pixel                                     valid && ready
// res_out   out  max_value, out_row, out_col, last         valid && ready
// cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// Front end takes one pixel per cycle while the queue has room; the back end
// scans each result's clipped window one pixel at a time through the single
// read port of the line store, in states B_START, B_SCAN, B_FIN and B_EMIT.
// After a register write the next pixel waits while the trackers realign in
// the wrap and seek states.
// Reset clears position counters and control; line store is not cleared.
// Output is registered; a stalled result holds while new pixels keep queuing.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_WINDOW = 8,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mp2d_pkg::CFG_W-1:0]        cfg_data_i,
  mp2d_pix_if.sink                               pix_in,
  mp2d_res_if.source                             res_out
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned NSLOT  = 2 ** $clog2(MAX_WINDOW + QDEPTH);
  localparam int unsigned SLW    = $clog2(NSLOT);
  localparam int unsigned PITCH  = 2 ** $clog2(MAX_WIDTH);
  localparam int unsigned DEPTH  = NSLOT * PITCH;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned QW     = $bits(mp2d_pkg::task_t) + SLW;

  logic [mp2d_pkg::WIN_W-1:0]  win_h_q, win_w_q, str_r_q, str_c_q;
  logic [mp2d_pkg::PAD_W-1:0]  pad_r_q, pad_c_q;
  logic [mp2d_pkg::SIZE_W-1:0] pl_h_q, pl_w_q;
  mp2d_pkg::cfg_t              cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_h_q <= 4'd2;
      win_w_q <= 4'd2;
      str_r_q <= 4'd2;
      str_c_q <= 4'd2;
      pad_r_q <= 3'd0;
      pad_c_q <= 3'd0;
      pl_h_q  <= 9'd32;
      pl_w_q  <= 9'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mp2d_pkg::REG_WIN_H:    win_h_q <= cfg_data_i[3:0];
        mp2d_pkg::REG_WIN_W:    win_w_q <= cfg_data_i[3:0];
        mp2d_pkg::REG_STRIDE_R: str_r_q <= cfg_data_i[3:0];
        mp2d_pkg::REG_STRIDE_C: str_c_q <= cfg_data_i[3:0];
        mp2d_pkg::REG_PAD_R:    pad_r_q <= cfg_data_i[2:0];
        mp2d_pkg::REG_PAD_C:    pad_c_q <= cfg_data_i[2:0];
        mp2d_pkg::REG_PLANE_H:  pl_h_q  <= cfg_data_i;
        mp2d_pkg::REG_PLANE_W:  pl_w_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one, large values saturate
  always_comb begin
    cfg.win_h = (win_h_q == '0) ? 4'd1 :
                ((32'(win_h_q) > MAX_WINDOW) ? 4'(MAX_WINDOW) : win_h_q);
    cfg.win_w = (win_w_q == '0) ? 4'd1 :
                ((32'(win_w_q) > MAX_WINDOW) ? 4'(MAX_WINDOW) : win_w_q);
    cfg.stride_r = (str_r_q == '0) ? 4'd1 :
                   ((32'(str_r_q) > mp2d_pkg::MAX_STRIDE) ?
                    4'(mp2d_pkg::MAX_STRIDE) : str_r_q);
    cfg.stride_c = (str_c_q == '0) ? 4'd1 :
                   ((32'(str_c_q) > mp2d_pkg::MAX_STRIDE) ?
                    4'(mp2d_pkg::MAX_STRIDE) : str_c_q);
    cfg.pad_r = ({1'b0, pad_r_q} > cfg.win_h - 4'd1) ? 3'(cfg.win_h - 4'd1) : pad_r_q;
    cfg.pad_c = ({1'b0, pad_c_q} > cfg.win_w - 4'd1) ? 3'(cfg.win_w - 4'd1) : pad_c_q;
    cfg.plane_h = (pl_h_q == '0) ? 9'd1 :
                  ((32'(pl_h_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : pl_h_q);
    cfg.plane_w = (pl_w_q == '0) ? 9'd1 :
                  ((32'(pl_w_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : pl_w_q);
  end

  logic                  push, pop, q_full, q_empty;
  mp2d_pkg::task_t       f_task, b_task;
  logic [SLW-1:0]        f_slot, b_slot;
  logic [QW-1:0]         q_rdata;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  mp2d_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .PITCH      (PITCH),
    .NSLOT      (NSLOT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_wr_i    (cfg_we_i),
    .pix_in      (pix_in),
    .q_full_i    (q_full),
    .push_o      (push),
    .task_o      (f_task),
    .slot_o      (f_slot),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  mp2d_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_slot, f_task}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_slot, b_task} = q_rdata;

  mp2d_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mp2d_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .PITCH      (PITCH),
    .NSLOT      (NSLOT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_task_i    (b_task),
    .q_slot_i    (b_slot),
    .q_pop_o     (pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_out     (res_out)
  );

endmodule

`default_nettype wire

### bench/max_pool_2d_stream_if_tb.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream_if_tb
// Result record for the pooling bench, shared by the bench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mp2d_tb_pkg;

  typedef struct {
    logic signed [15:0] max_value;
    logic [8:0]         out_row;
    logic [8:0]         out_col;
    logic               last;
  } pool_res_t;

endpackage

### bench/max_pool_2d_stream_tb.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream_tb
// Drives pixel planes through the 2-D max pool under several window, stride,
// padding and plane settings, with random gaps on both channels and one long
// output stall; checks every pooled result against a local model or typed want.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_pool_2d_stream_tb;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [2:0]             idx;
    logic [8:0]             data;
    logic signed [15:0]     pixel;
    logic                   typed;
    mp2d_tb_pkg::pool_res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mp2d_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [mp2d_pkg::CFG_W-1:0] cfg_data_i = '0;

  mp2d_pix_if #(.DATA_WIDTH(16)) pix ();
  mp2d_res_if #(.DATA_WIDTH(16)) res ();

  max_pool_2d_stream dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pix_in(pix), .res_out(res)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  logic [8:0]             cfg_reg [8];
  logic signed [15:0]     line_mem [0:2047];
  int                     row_pos, col_pos;
  int                     close_k [2][16];
  int                     close_s [2][16];
  int                     close_n [2];
  mp2d_tb_pkg::pool_res_t fresh_q [$];
  mp2d_tb_pkg::pool_res_t pending_q [$];
  stim_row_t              stim_rows [$];

  int  errors = 0;
  int  pix_sent = 0;
  bit  fast_mode = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int clampv(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int reg_bits(int idx);
    case (idx)
      mp2d_pkg::REG_PAD_R, mp2d_pkg::REG_PAD_C:     return 3;
      mp2d_pkg::REG_PLANE_H, mp2d_pkg::REG_PLANE_W: return 9;
      default:                                      return 4;
    endcase
  endfunction

  // pooled indices along one axis whose clipped window ends at pos
  task automatic find_closing(input int pos, input int size, input int pad, input int win,
                              input int stride, input int dim);
    int cnt, num, k, s, e;
    cnt = 0;
    num = size + 2 * pad - win;
    num = (num < 0) ? 0 : num / stride + 1;
    for (k = 0; k < num && cnt < 16; k++) begin
      s = k * stride - pad;
      e = s + win;
      if (e > size) e = size;
      if (e - 1 == pos) begin
        close_k[dim][cnt] = k;
        close_s[dim][cnt] = (s < 0) ? 0 : s;
        cnt++;
      end
    end
    close_n[dim] = cnt;
  endtask

  task automatic pool_predict(input logic signed [15:0] px);
    int wh, ww, sr, sc, pr, pc, ph, pw, r, c, a, b, h, w, n;
    logic signed [15:0] best;
    mp2d_tb_pkg::pool_res_t item;
    wh = clampv(cfg_reg[mp2d_pkg::REG_WIN_H], 8);
    ww = clampv(cfg_reg[mp2d_pkg::REG_WIN_W], 8);
    sr = clampv(cfg_reg[mp2d_pkg::REG_STRIDE_R], 8);
    sc = clampv(cfg_reg[mp2d_pkg::REG_STRIDE_C], 8);
    pr = cfg_reg[mp2d_pkg::REG_PAD_R];
    pc = cfg_reg[mp2d_pkg::REG_PAD_C];
    ph = clampv(cfg_reg[mp2d_pkg::REG_PLANE_H], 256);
    pw = clampv(cfg_reg[mp2d_pkg::REG_PLANE_W], 256);
    if (pr > wh - 1) pr = wh - 1;
    if (pc > ww - 1) pc = ww - 1;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ph) row_pos = 0;
    r = row_pos;
    c = col_pos;
    line_mem[(r % 8) * 256 + c] = px;
    find_closing(r, ph, pr, wh, sr, 0);
    find_closing(c, pw, pc, ww, sc, 1);
    n = 0;
    for (a = 0; a < close_n[0]; a++) begin
      for (b = 0; b < close_n[1] && n < 64; b++) begin
        best = px;
        for (h = close_s[0][a]; h <= r; h++)
          for (w = close_s[1][b]; w <= c; w++)
            if (line_mem[(h % 8) * 256 + w] > best) best = line_mem[(h % 8) * 256 + w];
        item.max_value = best;
        item.out_row   = 9'(close_k[0][a]);
        item.out_col   = 9'(close_k[1][b]);
        item.last      = 1'b0;
        fresh_q.push_back(item);
        n++;
      end
    end
    if (n > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
    col_pos++;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ph) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input logic signed [15:0] px, input logic typed,
                            input mp2d_tb_pkg::pool_res_t want);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pix_sent++;
    fresh_q.delete();
    pool_predict(px);
    if (typed) begin
      pending_q.push_back(want);
    end else begin
      foreach (fresh_q[i]) pending_q.push_back(fresh_q[i]);
    end
  endtask

  task automatic send_random(input int count);
    mp2d_tb_pkg::pool_res_t none;
    none = '{default: '0};
    repeat (count) send_pixel(16'($urandom()), 1'b0, none);
  endtask

  // block idle: no result owed, then let trailing pixels drain
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // caller lowers cfg_we_i after the last write of a group
  task automatic cfg_write(input logic [2:0] idx, input logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_reg[idx] = val & 9'((1 << reg_bits(idx)) - 1);
  endtask

  task automatic finish_plane();
    int total;
    total = clampv(cfg_reg[mp2d_pkg::REG_PLANE_H], 256) *
            clampv(cfg_reg[mp2d_pkg::REG_PLANE_W], 256);
    send_random((total - (row_pos * clampv(cfg_reg[mp2d_pkg::REG_PLANE_W], 256) +
                          col_pos)) % total);
  endtask

  function automatic logic [8:0] rand_cfg(int idx);
    case (idx)
      mp2d_pkg::REG_PAD_R, mp2d_pkg::REG_PAD_C:     return 9'($urandom_range(0, 7));
      mp2d_pkg::REG_PLANE_H, mp2d_pkg::REG_PLANE_W: return 9'($urandom_range(0, 12));
      default:                                      return 9'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [8:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: val, pixel: '0, typed: 1'b0,
            want: '{default: '0}};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_pix(logic signed [15:0] px, logic typed);
    stim_row_t row;
    row = '{kind: ROW_PIX, idx: '0, data: '0, pixel: px, typed: typed,
            want: '{max_value: px, out_row: 9'd0, out_col: 9'd0, last: 1'b1}};
    stim_rows.push_back(row);
  endfunction

  // result side
  initial begin
    mp2d_tb_pkg::pool_res_t want;
    int gap;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = fast_mode ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: max %0d row %0d col %0d last %0b",
                   res.max_value, res.out_row, res.out_col, res.last);
      end else begin
        want = pending_q.pop_front();
        if (res.max_value !== want.max_value || res.out_row !== want.out_row ||
            res.out_col !== want.out_col || res.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp max %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                     want.max_value, want.out_row, want.out_col, want.last,
                     res.max_value, res.out_row, res.out_col, res.last);
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    row_kind_e prev;
    int tweak;
    cfg_reg = '{9'd2, 9'd2, 9'd2, 9'd2, 9'd0, 9'd0, 9'd32, 9'd32};
    row_pos = 0;
    col_pos = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;

    // 1x1 plane and window: each pixel is its own maximum; zero clamps to one,
    // padding clamps below the window
    add_cfg(mp2d_pkg::REG_WIN_H, 9'd0);    add_cfg(mp2d_pkg::REG_WIN_W, 9'd0);
    add_cfg(mp2d_pkg::REG_STRIDE_R, 9'd0); add_cfg(mp2d_pkg::REG_STRIDE_C, 9'd0);
    add_cfg(mp2d_pkg::REG_PAD_R, 9'd5);    add_cfg(mp2d_pkg::REG_PAD_C, 9'd7);
    add_cfg(mp2d_pkg::REG_PLANE_H, 9'd0);  add_cfg(mp2d_pkg::REG_PLANE_W, 9'd1);
    add_pix(-16'sd32768, 1'b1); add_pix(16'sd32767, 1'b1); add_pix(16'sd0, 1'b1);
    add_pix(-16'sd1, 1'b1);     add_pix(16'sd1, 1'b1);     add_pix(16'sh5555, 1'b1);
    add_pix(16'shaaaa, 1'b1);
    // padded 2x2 plane: windows overlap, several close on one pixel
    add_cfg(mp2d_pkg::REG_WIN_H, 9'd2);    add_cfg(mp2d_pkg::REG_WIN_W, 9'd2);
    add_cfg(mp2d_pkg::REG_STRIDE_R, 9'd1); add_cfg(mp2d_pkg::REG_STRIDE_C, 9'd1);
    add_cfg(mp2d_pkg::REG_PAD_R, 9'd1);    add_cfg(mp2d_pkg::REG_PAD_C, 9'd1);
    add_cfg(mp2d_pkg::REG_PLANE_H, 9'd2);  add_cfg(mp2d_pkg::REG_PLANE_W, 9'd2);
    add_pix(-16'sd5, 1'b0); add_pix(16'sd9, 1'b0); add_pix(16'sd32767, 1'b0);
    add_pix(-16'sd32768, 1'b0);
    // window larger than plane: no results
    add_cfg(mp2d_pkg::REG_WIN_H, 9'd15); add_cfg(mp2d_pkg::REG_WIN_W, 9'd8);
    add_pix(16'sd3, 1'b0); add_pix(16'sd4, 1'b0); add_pix(16'sd5, 1'b0);
    add_pix(16'sd6, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    prev = ROW_PIX;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (prev == ROW_PIX) settle();
        cfg_write(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        if (prev == ROW_CFG) cfg_we_i <= 1'b0;
        send_pixel(stim_rows[i].pixel, stim_rows[i].typed, stim_rows[i].want);
      end
      prev = stim_rows[i].kind;
    end

    // largest window, unit stride, full padding: last pixel closes 64 windows;
    // output held off long enough for the input to back up
    settle();
    cfg_write(mp2d_pkg::REG_WIN_H, 9'd8);    cfg_write(mp2d_pkg::REG_WIN_W, 9'd8);
    cfg_write(mp2d_pkg::REG_STRIDE_R, 9'd1); cfg_write(mp2d_pkg::REG_STRIDE_C, 9'd1);
    cfg_write(mp2d_pkg::REG_PAD_R, 9'd7);    cfg_write(mp2d_pkg::REG_PAD_C, 9'd7);
    cfg_write(mp2d_pkg::REG_PLANE_H, 9'd8);  cfg_write(mp2d_pkg::REG_PLANE_W, 9'd8);
    cfg_we_i <= 1'b0;
    hold_req = 1'b1;
    send_random(64);

    // widest plane, saturated sizes and strides
    settle();
    cfg_write(mp2d_pkg::REG_WIN_H, 9'd1);    cfg_write(mp2d_pkg::REG_WIN_W, 9'd15);
    cfg_write(mp2d_pkg::REG_STRIDE_R, 9'd0); cfg_write(mp2d_pkg::REG_STRIDE_C, 9'd15);
    cfg_write(mp2d_pkg::REG_PAD_R, 9'd7);    cfg_write(mp2d_pkg::REG_PAD_C, 9'd7);
    cfg_write(mp2d_pkg::REG_PLANE_H, 9'd256); cfg_write(mp2d_pkg::REG_PLANE_H, 9'd0);
    cfg_write(mp2d_pkg::REG_PLANE_W, 9'd511);
    cfg_we_i <= 1'b0;
    send_random(256);

    // random settings; plane sizes only change at a plane boundary
    pix_sent = 0;
    while (pix_sent < 270) begin
      tweak = ($urandom_range(0, 3) == 0);
      if (!tweak) finish_plane();
      settle();
      for (int r = 0; r < 8; r++) begin
        if (tweak && r >= mp2d_pkg::REG_PLANE_H) continue;
        if ($urandom_range(0, 1) == 1) cfg_write(3'(r), rand_cfg(r));
      end
      cfg_we_i <= 1'b0;
      fast_mode = ($urandom_range(0, 3) == 0);
      send_random($urandom_range(4, 40));
    end

    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
